// File: hw/rtl/gslc_pkg.sv
`default_nettype none
package gslc_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int CODE_W = 16;
  localparam int SLOT_W = 8;
  localparam int AGE_W = 8;
  localparam int CAP_W = 9;
  localparam int LEN_W = 16;
  localparam int CNT_W = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
  localparam logic [AGE_W-1:0] AGE_LIMIT = 8'hff;
  localparam logic [CNT_W-1:0] CNT_LIMIT = 16'hffff;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
    logic [AGE_W-1:0]  age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BATCH,
    OP_AGE_RD,
    OP_AGE_WR,
    OP_SINIT,
    OP_SRCH,
    OP_SCMP,
    OP_PROBE,
    OP_HIT,
    OP_FILL_FREE,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_MV_INIT,
    OP_DN_RD,
    OP_DN_WR,
    OP_UP_RD,
    OP_UP_WR,
    OP_PLACE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic overflow;
    logic used_zero;
    logic lo_lt_hi;
    logic lo_lt_used;
    logic code_hit;
    logic room;
    logic idx_last;
    logic mv_down;
    logic mv_up;
    logic dn_done;
    logic up_done;
  } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/gslc_ram.sv
`default_nettype none
module gslc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/gslc_ctrl.sv
`default_nettype none
module gslc_ctrl
  import gslc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  input  wire stat_t st,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_BATCH, S_AGE_RD, S_AGE_WR, S_SINIT, S_SRCH, S_SCMP, S_PROBE, S_PCHK,
    S_MISS, S_SCAN_RD, S_SCAN_CMP, S_MVSEL, S_DN_RD, S_DN_WR, S_UP_RD, S_UP_WR, S_PLACE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          state_next = S_BATCH;
        end
      end
      S_BATCH: begin
        if (st.first) begin
          cmd.op = OP_BATCH;
          state_next = (st.overflow && !st.used_zero) ? S_AGE_RD : S_SINIT;
        end else begin
          state_next = S_SINIT;
        end
      end
      S_AGE_RD: begin
        cmd.op = OP_AGE_RD;
        state_next = S_AGE_WR;
      end
      S_AGE_WR: begin
        cmd.op = OP_AGE_WR;
        state_next = st.idx_last ? S_SINIT : S_AGE_RD;
      end
      S_SINIT: begin
        cmd.op = OP_SINIT;
        state_next = S_SRCH;
      end
      S_SRCH: begin
        cmd.op = OP_SRCH;
        state_next = st.lo_lt_hi ? S_SCMP : S_PROBE;
      end
      S_SCMP: begin
        cmd.op = OP_SCMP;
        state_next = S_SRCH;
      end
      S_PROBE: begin
        cmd.op = OP_PROBE;
        state_next = st.lo_lt_used ? S_PCHK : S_MISS;
      end
      S_PCHK: begin
        if (st.code_hit) begin
          cmd.op = OP_HIT;
          state_next = S_IDLE;
        end else begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        if (st.room) begin
          cmd.op = OP_FILL_FREE;
          state_next = S_MVSEL;
        end else begin
          cmd.op = OP_SCAN_INIT;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.op = OP_SCAN_RD;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.op = OP_SCAN_CMP;
        state_next = st.idx_last ? S_MVSEL : S_SCAN_RD;
      end
      S_MVSEL: begin
        cmd.op = OP_MV_INIT;
        if (st.mv_down) begin
          state_next = S_DN_RD;
        end else if (st.mv_up) begin
          state_next = S_UP_RD;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_RD: begin
        cmd.op = OP_DN_RD;
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.op = OP_DN_WR;
        state_next = st.dn_done ? S_PLACE : S_DN_RD;
      end
      S_UP_RD: begin
        cmd.op = OP_UP_RD;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.op = OP_UP_WR;
        state_next = st.up_done ? S_PLACE : S_UP_RD;
      end
      S_PLACE: begin
        cmd.op = OP_PLACE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
    end
  end

  // Results leave only from the two terminal states, and both return to idle.
  a_term_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_HIT || cmd.op == OP_PLACE) |=> !busy)
    else $error("terminal step did not return to idle");
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy out of step with state");
  a_start_taken: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule
`default_nettype wire

// File: hw/rtl/gslc_dp.sv
`default_nettype none
module gslc_dp
  import gslc_pkg::*;
#(
  parameter int MaxEntries = MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output stat_t                  st,
  input  wire logic [CODE_W-1:0] code,
  input  wire logic              first_of_batch,
  input  wire logic [LEN_W-1:0]  batch_length,
  input  wire logic              cfg_we,
  input  wire logic [CAP_W-1:0]  cfg_data,
  output logic      [CAP_W-1:0]  capacity,
  output logic                   done,
  output logic      [SLOT_W-1:0] slot,
  output logic                   is_new,
  output logic      [CNT_W-1:0]  new_count
);

  localparam int AW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  logic [CntW-1:0]   used, lo, hi, capu;
  logic [LEN_W-1:0]  turn, len;
  logic [CNT_W-1:0]  misses, misses_inc;
  logic [CODE_W-1:0] key;
  logic              first;
  logic [AW-1:0]     mid, idx, ins, k, dest;
  logic [AGE_W-1:0]  best_age;
  logic [SLOT_W-1:0] slot_new;

  logic [LEN_W-1:0]  len1;
  logic [CmpW-1:0]   cap_ext;
  logic [AW-1:0]     mid_c;
  logic [CntW:0]     ins_w;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  entry_t            wdata, rd;
  logic [ENTRY_W-1:0] rdata_raw;

  gslc_ram #(.Width(ENTRY_W), .Depth(MaxEntries)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rd = entry_t'(rdata_raw);

  always_comb begin
    cap_ext = CmpW'(capacity);
    if (cap_ext == '0) begin
      capu = CntW'(1);
    end else if (cap_ext > CmpW'(MaxEntries)) begin
      capu = CntW'(MaxEntries);
    end else begin
      capu = CntW'(cap_ext);
    end
  end

  assign len1 = (len == '0) ? LEN_W'(1) : len;
  assign mid_c = AW'(((CntW + 1)'(lo) + (CntW + 1)'(hi)) >> 1);
  assign ins_w = (CntW + 1)'(ins);
  assign misses_inc = (misses == CNT_LIMIT) ? misses : misses + CNT_W'(1);

  always_comb begin
    st.first = first;
    st.overflow = ((LEN_W + 1)'(turn) + (LEN_W + 1)'(len1)) > (LEN_W + 1)'(capu);
    st.used_zero = (used == '0);
    st.lo_lt_hi = (lo < hi);
    st.lo_lt_used = (lo < used);
    st.code_hit = (rd.code == key);
    st.room = (used < capu);
    st.idx_last = ((CntW'(idx) + CntW'(1)) == used);
    st.mv_down = ((CntW + 1)'(lo) < ins_w);
    st.mv_up = ((CntW + 1)'(lo) > ins_w + (CntW + 1)'(1));
    st.dn_done = ((k - AW'(1)) == dest);
    st.up_done = ((k + AW'(1)) == dest);
  end

  always_comb begin
    we = 1'b0;
    waddr = idx;
    raddr = idx;
    wdata = rd;
    case (cmd.op)
      OP_AGE_RD, OP_SCAN_RD: raddr = idx;
      OP_AGE_WR: begin
        we = 1'b1;
        wdata.age = (rd.age == AGE_LIMIT) ? rd.age : rd.age + AGE_W'(1);
      end
      OP_SRCH: raddr = mid_c;
      OP_PROBE: raddr = AW'(lo);
      OP_HIT: begin
        we = 1'b1;
        waddr = AW'(lo);
        wdata = '{code: key, slot: rd.slot, age: '0};
      end
      OP_DN_RD: raddr = k - AW'(1);
      OP_UP_RD: raddr = k + AW'(1);
      OP_DN_WR, OP_UP_WR: begin
        we = 1'b1;
        waddr = k;
      end
      OP_PLACE: begin
        we = 1'b1;
        waddr = dest;
        wdata = '{code: key, slot: slot_new, age: '0};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      used <= '0;
      turn <= '0;
      misses <= '0;
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_HIT) || (cmd.op == OP_PLACE);
      if (cfg_we) begin
        capacity <= cfg_data;
        used <= '0;
        turn <= '0;
        misses <= '0;
      end
      case (cmd.op)
        OP_LOAD: begin
          key <= code;
          first <= first_of_batch;
          len <= batch_length;
        end
        OP_BATCH: begin
          turn <= st.overflow ? len1 : turn + len1;
          misses <= '0;
          idx <= '0;
        end
        OP_AGE_WR, OP_SCAN_CMP: idx <= idx + AW'(1);
        OP_SINIT: begin
          lo <= '0;
          hi <= used;
        end
        OP_SRCH: mid <= mid_c;
        OP_SCMP: begin
          if (rd.code < key) begin
            lo <= CntW'(mid) + CntW'(1);
          end else begin
            hi <= CntW'(mid);
          end
        end
        OP_HIT: begin
          slot <= rd.slot;
          is_new <= 1'b0;
          new_count <= misses;
        end
        OP_FILL_FREE: begin
          ins <= AW'(used);
          slot_new <= SLOT_W'(used);
          used <= used + CntW'(1);
        end
        OP_SCAN_INIT: idx <= '0;
        OP_MV_INIT: begin
          k <= ins;
          if (st.mv_up) begin
            dest <= AW'(lo - CntW'(1));
          end else if (st.mv_down) begin
            dest <= AW'(lo);
          end else begin
            dest <= ins;
          end
        end
        OP_DN_WR: k <= k - AW'(1);
        OP_UP_WR: k <= k + AW'(1);
        OP_PLACE: begin
          misses <= misses_inc;
          slot <= slot_new;
          is_new <= 1'b1;
          new_count <= misses_inc;
        end
        default: begin
        end
      endcase
      if (cmd.op == OP_SCAN_CMP) begin
        if (idx == '0 || rd.age > best_age) begin
          best_age <= rd.age;
          ins <= idx;
          slot_new <= rd.slot;
        end
      end
    end
  end

  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used <= capu)
    else $error("table fill above capacity in use");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");
  a_place_in_table: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PLACE) |-> (CntW'(dest) < used))
    else $error("new entry placed outside the used part of the table");

endmodule
`default_nettype wire

// File: hw/rtl/glyph_slot_lru_cache.sv
// A request may walk the table for aging, the binary search, the oldest-entry scan and the
// shift that keeps it sorted, so its length grows with the number of used entries; every
// table walk goes through the single entry RAM.
// Throughput: one request at a time; busy is high from the cycle after acceptance and drops
// in the cycle that done is high, so the next request can be accepted as the result leaves.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset: synchronous, active high; capacity returns to 256 and the table is empty.
`default_nettype none
module glyph_slot_lru_cache
  import gslc_pkg::*;
#(
  parameter int MaxEntries = MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Request channel: accepted when start is high and busy is low.
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CODE_W-1:0] code,
  input  wire logic              first_of_batch,
  input  wire logic [LEN_W-1:0]  batch_length,
  // Result channel: valid for exactly one cycle while done is high.
  output logic                   done,
  output logic      [SLOT_W-1:0] slot,
  output logic                   is_new,
  output logic      [CNT_W-1:0]  new_count,
  // Register port. The capacity register sits at byte address zero.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cmd_t             cmd;
  stat_t            st;
  logic             cfg_we;
  logic [CAP_W-1:0] capacity;

  // The block never inserts wait states. A write to capacity also empties the table, so
  // software must write it only while the block is idle; the block does not enforce this.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(capacity) : 32'd0;

  // The controller sequences aging, the binary search, the oldest-entry scan and the
  // shift that keeps the table sorted; the datapath owns the entry RAM and counters.
  gslc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  gslc_dp #(.MaxEntries(MaxEntries)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .code          (code),
    .first_of_batch(first_of_batch),
    .batch_length  (batch_length),
    .cfg_we        (cfg_we),
    .cfg_data      (pwdata[CAP_W-1:0]),
    .capacity      (capacity),
    .done          (done),
    .slot          (slot),
    .is_new        (is_new),
    .new_count     (new_count)
  );

endmodule
`default_nettype wire
